FILE: hw/rtl/sfe_pkg.sv
`timescale 1ns / 1ps
// sfe_pkg: shared types, command bytes, register indexes and segment fonts
// for the seven segment frame encoder. No dependencies.
package sfe_pkg;

   localparam int MAX_DIGITS = 8;

   localparam logic [2:0] ACT_HEX    = 3'd0;
   localparam logic [2:0] ACT_DEC    = 3'd1;
   localparam logic [2:0] ACT_TEXT   = 3'd2;
   localparam logic [2:0] ACT_SINGLE = 3'd3;
   localparam logic [2:0] ACT_RAW    = 3'd4;

   localparam logic [7:0] CMD_AUTO_WRITE  = 8'h40;
   localparam logic [7:0] CMD_FIXED_WRITE = 8'h44;
   localparam logic [7:0] CMD_ADDR        = 8'hC0;

   localparam logic [7:0] RST_LED_EVEN     = 8'hFC;
   localparam logic [7:0] RST_LED_ODD      = 8'hFF;
   localparam logic [7:0] RST_DISPLAY_CTRL = 8'h89;

   localparam logic [1:0] REG_LED_EVEN     = 2'd0;
   localparam logic [1:0] REG_LED_ODD      = 2'd1;
   localparam logic [1:0] REG_DISPLAY_CTRL = 2'd2;

   localparam logic [4:0] STEP_CMD  = 5'd0;
   localparam logic [4:0] STEP_ADDR = 5'd1;
   localparam logic [4:0] STEP_DATA = 5'd2;
   localparam logic [4:0] STEP_CTRL = 5'd3;

   localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;

   typedef enum logic [1:0] {
      KIND_REFRESH,
      KIND_SINGLE,
      KIND_RAW
   } kind_type;

   typedef enum logic [1:0] {
      FE_EMPTY,
      FE_CONV,
      FE_READY
   } front_state_type;

   typedef struct packed {
      kind_type                    kind;
      logic [3:0]                  pos;
      logic [7:0]                  value;
      logic [MAX_DIGITS-1:0][7:0]  seg;
   } entry_type;

   typedef struct packed {
      logic [7:0] led_even;
      logic [7:0] led_odd;
      logic [7:0] display_control;
   } cfg_type;

   localparam logic [7:0] HEX_FONT [16] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
   };

   // printable ASCII, space through tilde
   localparam logic [7:0] CHAR_FONT [95] = '{
      8'h00, 8'h86, 8'h22, 8'h7E, 8'h6D, 8'h00, 8'h00, 8'h02,
      8'h30, 8'h06, 8'h63, 8'h00, 8'h04, 8'h40, 8'h80, 8'h52,
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
      8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
      8'h5F, 8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h3D,
      8'h76, 8'h06, 8'h1F, 8'h69, 8'h38, 8'h15, 8'h37, 8'h3F,
      8'h73, 8'h67, 8'h31, 8'h6D, 8'h78, 8'h3E, 8'h2A, 8'h1D,
      8'h76, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h00, 8'h08,
      8'h20, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h31, 8'h6F,
      8'h74, 8'h04, 8'h0E, 8'h75, 8'h30, 8'h55, 8'h54, 8'h5C,
      8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h2A, 8'h1D,
      8'h76, 8'h6E, 8'h47, 8'h46, 8'h06, 8'h70, 8'h01
   };

   function automatic logic [7:0] hex_seg(input logic [3:0] nibble);
      return HEX_FONT[nibble];
   endfunction

   function automatic logic [7:0] char_seg(input logic [7:0] c);
      if (c < 8'd32 || c > 8'd126) begin
         return 8'h00;
      end
      return CHAR_FONT[7'(c - 8'd32)];
   endfunction

   function automatic logic [7:0] dec_seg(input logic [3:0] d);
      return CHAR_FONT[7'(d) + 7'd16];
   endfunction

endpackage

FILE: hw/rtl/sfe_front.sv
`timescale 1ns / 1ps
// sfe_front: accepts request items, builds segment bytes and runs the
// decimal conversion (one digit per cycle). Depends on sfe_pkg.
module sfe_front import sfe_pkg::*; #(
   parameter int DIGIT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_hex_digits,
   input  logic [30:0] req_number_value,
   input  logic [63:0] req_text,
   input  logic [3:0]  req_position,
   input  logic [7:0]  req_raw_byte,
   output entry_type   q_data,
   output logic        q_push,
   input  logic        q_full
);

   localparam logic [2:0] LAST_DIGIT = 3'(DIGIT_COUNT - 1);

   front_state_type state_ff, state_in;
   entry_type       ent_ff, ent_in;
   logic [30:0]     t_ff, t_in;
   logic [2:0]      cnt_ff, cnt_in;

   logic [62:0]     prod;
   logic [27:0]     quot;
   logic [3:0]      digit;
   logic            accept;

   assign prod   = 63'(t_ff) * 63'(RECIP_10);
   assign quot   = prod[62:35];
   assign digit  = t_ff[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
   assign q_push = (state_ff == FE_READY) && !q_full;
   assign full   = (state_ff == FE_CONV) || ((state_ff == FE_READY) && q_full);
   assign accept = push && !full;
   assign q_data = ent_ff;

   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      t_in     = t_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         FE_CONV: begin
            ent_in.seg[LAST_DIGIT - cnt_ff] = dec_seg(digit);
            t_in   = 31'(quot);
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == LAST_DIGIT) begin
               state_in = FE_READY;
            end
         end
         FE_READY: begin
            if (!q_full) begin
               state_in = FE_EMPTY;
            end
         end
         FE_EMPTY: begin
         end
         default: begin
            state_in = FE_EMPTY;
         end
      endcase
      if (accept) begin
         ent_in.pos   = req_position;
         ent_in.value = req_raw_byte;
         ent_in.kind  = KIND_REFRESH;
         t_in         = req_number_value;
         cnt_in       = 3'd0;
         state_in     = FE_READY;
         unique case (req_action)
            ACT_HEX: begin
               for (int p = 0; p < MAX_DIGITS; p++) begin
                  ent_in.seg[p] = hex_seg(req_hex_digits[31 - 4 * p -: 4]);
               end
            end
            ACT_DEC: begin
               state_in = FE_CONV;
            end
            ACT_TEXT: begin
               for (int p = 0; p < MAX_DIGITS; p++) begin
                  ent_in.seg[p] = char_seg(req_text[63 - 8 * p -: 8]);
               end
            end
            ACT_SINGLE: begin
               ent_in.kind  = KIND_SINGLE;
               ent_in.value = hex_seg(req_number_value[3:0]);
            end
            ACT_RAW: begin
               ent_in.kind = KIND_RAW;
            end
            default: begin
               state_in = FE_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_EMPTY;
      end else begin
         state_ff <= state_in;
      end
      ent_ff <= ent_in;
      t_ff   <= t_in;
      cnt_ff <= cnt_in;
   end

endmodule

FILE: hw/rtl/sfe_queue.sv
`timescale 1ns / 1ps
// sfe_queue: two-entry queue of classified items between front and back.
// Depends on sfe_pkg.
module sfe_queue import sfe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_push,
   input  entry_type q_wdata,
   output logic      q_full,
   input  logic      q_pop,
   output entry_type q_rdata,
   output logic      q_empty
);

   entry_type   mem_ff [2];
   entry_type   mem_in [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign q_rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         mem_in[wr_ptr_ff] = q_wdata;
         wr_ptr_in         = !wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      mem_ff <= mem_in;
   end

endmodule

FILE: hw/rtl/sfe_back.sv
`timescale 1ns / 1ps
// sfe_back: walks the byte sequence of the head item and feeds the result
// register, one byte per cycle while pop is high. Depends on sfe_pkg.
module sfe_back import sfe_pkg::*; #(
   parameter int DIGIT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   q_rdata,
   input  logic        q_empty,
   output logic        q_pop,
   input  cfg_type     cfg,
   input  logic        pop,
   output logic        empty,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_frame_end,
   output logic        rsp_last
);

   localparam logic [2:0] LAST_DIGIT = 3'(DIGIT_COUNT - 1);
   localparam logic [4:0] LAST_STEP  = 5'(2 * DIGIT_COUNT + 1);

   logic [4:0] idx_ff, idx_in;
   logic       ovld_ff, ovld_in;
   logic [7:0] data_ff, data_in;
   logic       fe_ff, fe_in;
   logic       last_ff, last_in;

   logic [4:0] j;
   logic [2:0] p;
   logic [7:0] gen_data;
   logic       gen_fe;
   logic       gen_last;
   logic       adv;

   assign j = idx_ff - STEP_DATA;
   assign p = j[3:1];

   always_comb begin
      gen_data = 8'h00;
      gen_fe   = 1'b0;
      gen_last = 1'b0;
      unique case (q_rdata.kind)
         KIND_REFRESH: begin
            priority if (idx_ff == STEP_CMD) begin
               gen_data = CMD_AUTO_WRITE;
               gen_fe   = 1'b1;
            end else if (idx_ff == STEP_ADDR) begin
               gen_data = CMD_ADDR;
            end else if (!j[0]) begin
               gen_data = q_rdata.seg[p];
            end else begin
               gen_data = p[0] ? cfg.led_odd : cfg.led_even;
               gen_fe   = (p == LAST_DIGIT);
               gen_last = (idx_ff == LAST_STEP);
            end
         end
         KIND_SINGLE, KIND_RAW: begin
            priority if (idx_ff == STEP_CMD) begin
               gen_data = CMD_FIXED_WRITE;
               gen_fe   = 1'b1;
            end else if (idx_ff == STEP_ADDR) begin
               gen_data = CMD_ADDR | {4'h0, q_rdata.pos};
            end else if (idx_ff == STEP_DATA) begin
               gen_data = q_rdata.value;
               gen_fe   = 1'b1;
               gen_last = (q_rdata.kind == KIND_RAW);
            end else begin
               gen_data = cfg.display_control;
               gen_fe   = 1'b1;
               gen_last = 1'b1;
            end
         end
         default: begin
            gen_last = 1'b1;
         end
      endcase
   end

   assign adv   = !q_empty && (!ovld_ff || pop);
   assign q_pop = adv && gen_last;
   assign empty = !ovld_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_frame_end = fe_ff;
   assign rsp_last      = last_ff;

   always_comb begin
      idx_in  = idx_ff;
      ovld_in = ovld_ff;
      data_in = data_ff;
      fe_in   = fe_ff;
      last_in = last_ff;
      if (adv) begin
         idx_in  = gen_last ? STEP_CMD : idx_ff + 5'd1;
         ovld_in = 1'b1;
         data_in = gen_data;
         fe_in   = gen_fe;
         last_in = gen_last;
      end else if (pop) begin
         ovld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= STEP_CMD;
         ovld_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         ovld_ff <= ovld_in;
      end
      data_ff <= data_in;
      fe_ff   <= fe_in;
      last_ff <= last_in;
   end

endmodule

FILE: hw/rtl/seven_segment_frame_encoder.sv
`timescale 1ns / 1ps
// Seven segment frame encoder: turns display requests into the byte stream
// of an eight-digit LED display controller.
// Depends on sfe_pkg, sfe_front, sfe_queue, sfe_back.
//
// Usage:
//   Request items enter through push/full, one item per accepted push.
//   Result items (one byte each, with frame_end and last) leave through
//   empty/pop; the oldest byte is on the rsp_ ports while empty is low.
//   Registers led_even, led_odd, display_control are written through the
//   APB port at byte addresses 0, 4 and 8; the user must write them only
//   while the block idles, which the block itself does not enforce.
// Path: front register, queue, result register; a decimal item first
//   converts in the front, one digit per cycle. Throughput: one byte per
//   cycle at the result side while pop is high and items wait. A refresh
//   item: 2 + 2*DIGIT_COUNT bytes (18), single 4, raw 3, from the back part.
//   A two-entry queue lets the front take the next item as bytes go out.
// Reset: synchronous; empties all stages and restores register defaults.
// Stall: while pop is low the current byte holds; the queue then fills and
//   full rises, no item is lost.
module seven_segment_frame_encoder import sfe_pkg::*; #(
   parameter int DIGIT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_hex_digits,
   input  logic [30:0] req_number_value,
   input  logic [63:0] req_text,
   input  logic [3:0]  req_position,
   input  logic [7:0]  req_raw_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_frame_end,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type   cfg_ff, cfg_in;
   entry_type fq_data;
   entry_type q_head;
   logic      fq_push;
   logic      fq_full;
   logic      q_pop;
   logic      q_empty;
   logic      wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_LED_EVEN:     cfg_in.led_even        = pwdata[7:0];
            REG_LED_ODD:      cfg_in.led_odd         = pwdata[7:0];
            REG_DISPLAY_CTRL: cfg_in.display_control = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_LED_EVEN:     prdata = {24'h0, cfg_ff.led_even};
         REG_LED_ODD:      prdata = {24'h0, cfg_ff.led_odd};
         REG_DISPLAY_CTRL: prdata = {24'h0, cfg_ff.display_control};
         default:          prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_even        <= RST_LED_EVEN;
         cfg_ff.led_odd         <= RST_LED_ODD;
         cfg_ff.display_control <= RST_DISPLAY_CTRL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfe_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_hex_digits   (req_hex_digits),
      .req_number_value (req_number_value),
      .req_text         (req_text),
      .req_position     (req_position),
      .req_raw_byte     (req_raw_byte),
      .q_data           (fq_data),
      .q_push           (fq_push),
      .q_full           (fq_full)
   );

   sfe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (fq_push),
      .q_wdata (fq_data),
      .q_full  (fq_full),
      .q_pop   (q_pop),
      .q_rdata (q_head),
      .q_empty (q_empty)
   );

   sfe_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_rdata       (q_head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .cfg           (cfg_ff),
      .pop           (pop),
      .empty         (empty),
      .rsp_data_byte (rsp_data_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: hw/rtl/sfe_checker.sv
`timescale 1ns / 1ps
// sfe_checker: port-level assertions for seven_segment_frame_encoder,
// attached by the bind at the end of this file.
module sfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_frame_end,
   input logic       rsp_last,
   input logic       pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data_byte)
                            && $stable(rsp_last)))
      else $error("stalled item changed");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last) |-> rsp_frame_end)
      else $error("last item of a request does not close a frame");

   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready dropped");

endmodule

bind seven_segment_frame_encoder sfe_checker u_sfe_checker (.*);

FILE: test/tb_seven_segment_frame_encoder.sv
`timescale 1ns / 1ps
// Testbench for seven_segment_frame_encoder: directed and random display requests,
// predicted byte streams checked against the result queue, APB register writes.
// Depends on sfe_pkg and the encoder RTL.
module tb_seven_segment_frame_encoder;
   import sfe_pkg::*;

   localparam int DIGITS         = 8;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [2:0] ACT_SPARE_MID = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
   localparam logic [1:0] REG_SPARE     = 2'd3;

   localparam logic [7:0] SEG_HEX [16] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
   };

   localparam logic [7:0] SEG_CHAR [95] = '{
      8'h00, 8'h86, 8'h22, 8'h7E, 8'h6D, 8'h00, 8'h00, 8'h02,
      8'h30, 8'h06, 8'h63, 8'h00, 8'h04, 8'h40, 8'h80, 8'h52,
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
      8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
      8'h5F, 8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h3D,
      8'h76, 8'h06, 8'h1F, 8'h69, 8'h38, 8'h15, 8'h37, 8'h3F,
      8'h73, 8'h67, 8'h31, 8'h6D, 8'h78, 8'h3E, 8'h2A, 8'h1D,
      8'h76, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h00, 8'h08,
      8'h20, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h31, 8'h6F,
      8'h74, 8'h04, 8'h0E, 8'h75, 8'h30, 8'h55, 8'h54, 8'h5C,
      8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h2A, 8'h1D,
      8'h76, 8'h6E, 8'h47, 8'h46, 8'h06, 8'h70, 8'h01
   };

   typedef struct {
      logic [2:0]  action;
      logic [31:0] hex_digits;
      logic [30:0] number_value;
      logic [63:0] text;
      logic [3:0]  position;
      logic [7:0]  raw_byte;
   } display_req_type;

   typedef struct packed {
      logic [7:0] data;
      logic       frame_end;
      logic       last;
   } wire_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_action = '0;
   logic [31:0] req_hex_digits = '0;
   logic [30:0] req_number_value = '0;
   logic [63:0] req_text = '0;
   logic [3:0]  req_position = '0;
   logic [7:0]  req_raw_byte = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_frame_end;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   wire_byte_type pending_bytes [$];
   logic [7:0]  led_even_reg = RST_LED_EVEN;
   logic [7:0]  led_odd_reg = RST_LED_ODD;
   logic [7:0]  display_ctrl_reg = RST_DISPLAY_CTRL;
   int          errors = 0;
   int          req_idle_pct = 20;
   int          rsp_idle_pct = 20;
   int          pop_hold = 0;
   int          quiet_cycles = 0;

   seven_segment_frame_encoder #(
      .DIGIT_COUNT(DIGITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_action(req_action),
      .req_hex_digits(req_hex_digits),
      .req_number_value(req_number_value),
      .req_text(req_text),
      .req_position(req_position),
      .req_raw_byte(req_raw_byte),
      .empty(empty),
      .pop(pop),
      .rsp_data_byte(rsp_data_byte),
      .rsp_frame_end(rsp_frame_end),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length(input int pct);
      if ($urandom_range(0, 99) >= pct) begin
         return 0;
      end
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] text_segment(input logic [7:0] c);
      if (c < 8'd32 || c > 8'd126) begin
         return 8'h00;
      end
      return SEG_CHAR[c - 8'd32];
   endfunction

   function automatic void add_byte(input logic [7:0] data, input logic fe, input logic lst);
      wire_byte_type b;
      b.data = data;
      b.frame_end = fe;
      b.last = lst;
      pending_bytes.push_back(b);
   endfunction

   function automatic void encode_request(input display_req_type r);
      logic [3:0]  dec [8];
      int unsigned t;
      logic [7:0]  seg;
      logic        tail;
      t = r.number_value;
      for (int i = 0; i < 8; i++) begin
         dec[i] = 4'(t % 10);
         t = t / 10;
      end
      case (r.action)
         ACT_HEX, ACT_DEC, ACT_TEXT: begin
            add_byte(CMD_AUTO_WRITE, 1'b1, 1'b0);
            add_byte(CMD_ADDR, 1'b0, 1'b0);
            for (int p = 0; p < DIGITS; p++) begin
               if (r.action == ACT_HEX) begin
                  seg = SEG_HEX[r.hex_digits[(7 - p) * 4 +: 4]];
               end else if (r.action == ACT_DEC) begin
                  seg = SEG_CHAR[dec[DIGITS - 1 - p] + 16];
               end else begin
                  seg = text_segment(r.text[(7 - p) * 8 +: 8]);
               end
               tail = (p == DIGITS - 1);
               add_byte(seg, 1'b0, 1'b0);
               add_byte((p % 2 == 1) ? led_odd_reg : led_even_reg, tail, tail);
            end
         end
         ACT_SINGLE: begin
            add_byte(CMD_FIXED_WRITE, 1'b1, 1'b0);
            add_byte(CMD_ADDR | {4'h0, r.position}, 1'b0, 1'b0);
            add_byte(SEG_HEX[r.number_value[3:0]], 1'b1, 1'b0);
            add_byte(display_ctrl_reg, 1'b1, 1'b1);
         end
         ACT_RAW: begin
            add_byte(CMD_FIXED_WRITE, 1'b1, 1'b0);
            add_byte(CMD_ADDR | {4'h0, r.position}, 1'b0, 1'b0);
            add_byte(r.raw_byte, 1'b1, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic display_req_type make_req(input logic [2:0] action,
                                                input logic [31:0] hex,
                                                input logic [30:0] num,
                                                input logic [63:0] text,
                                                input logic [3:0] pos,
                                                input logic [7:0] raw);
      display_req_type r;
      r.action = action;
      r.hex_digits = hex;
      r.number_value = num;
      r.text = text;
      r.position = pos;
      r.raw_byte = raw;
      return r;
   endfunction

   function automatic display_req_type random_req();
      display_req_type r;
      int              pick;
      if ($urandom_range(0, 99) < 8) begin
         r.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end else begin
         r.action = 3'($urandom_range(ACT_HEX, ACT_RAW));
      end
      r.hex_digits = $urandom;
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
         r.number_value = 31'($urandom);
      end else if (pick == 2) begin
         r.number_value = 31'($urandom_range(0, 99999999));
      end else begin
         r.number_value = 31'($urandom_range(0, 999));
      end
      if ($urandom_range(0, 9) < 6) begin
         for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               r.text[i * 8 +: 8] = 8'($urandom);
            end else begin
               r.text[i * 8 +: 8] = 8'($urandom_range(32, 126));
            end
         end
      end else begin
         r.text = {$urandom, $urandom};
      end
      r.position = 4'($urandom);
      r.raw_byte = 8'($urandom);
      return r;
   endfunction

   // returns right after the edge that accepted the item; push stays high
   task automatic send_request(input display_req_type r);
      int gap;
      gap = idle_length(req_idle_pct);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_action <= r.action;
      req_hex_digits <= r.hex_digits;
      req_number_value <= r.number_value;
      req_text <= r.text;
      req_position <= r.position;
      req_raw_byte <= r.raw_byte;
      push <= 1'b1;
      do @(posedge clock); while (full);
      encode_request(r);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_LED_EVEN:     led_even_reg = value[7:0];
         REG_LED_ODD:      led_odd_reg = value[7:0];
         REG_DISPLAY_CTRL: display_ctrl_reg = value[7:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [1:0] idx, input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {24'h0, value}) begin
         errors++;
         $display("%0t: register %0d read exp %h act %h", $time, idx, {24'h0, value}, prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] even, input logic [7:0] odd,
                               input logic [7:0] ctrl);
      csr_write(REG_LED_EVEN, ($urandom & 32'hFFFFFF00) | {24'h0, even});
      csr_write(REG_LED_ODD, ($urandom & 32'hFFFFFF00) | {24'h0, odd});
      csr_write(REG_DISPLAY_CTRL, ($urandom & 32'hFFFFFF00) | {24'h0, ctrl});
   endtask

   task automatic test_hex();
      send_request(make_req(ACT_HEX, 32'h00000000, '1, '1, '1, '1));
      send_request(make_req(ACT_HEX, 32'hFFFFFFFF, '0, '0, '0, '0));
      send_request(make_req(ACT_HEX, 32'h01234567, '0, '0, '0, '0));
      send_request(make_req(ACT_HEX, 32'h89ABCDEF, '0, '0, '0, '0));
   endtask

   // high digits above eight places are dropped
   task automatic test_decimal();
      send_request(make_req(ACT_DEC, '0, 31'd0, '0, '0, '0));
      send_request(make_req(ACT_DEC, '0, 31'd7, '0, '0, '0));
      send_request(make_req(ACT_DEC, '0, 31'd12345678, '0, '0, '0));
      send_request(make_req(ACT_DEC, '0, 31'd99999999, '0, '0, '0));
      send_request(make_req(ACT_DEC, '0, 31'd100000000, '0, '0, '0));
      send_request(make_req(ACT_DEC, '1, 31'h7FFFFFFF, '1, '1, '1));
   endtask

   // characters outside space..tilde show blank
   task automatic test_text();
      send_request(make_req(ACT_TEXT, '0, '0, 64'h001F207E7F80FF41, '0, '0));
      send_request(make_req(ACT_TEXT, '0, '0, 64'h48454C4C4F20776F, '0, '0));
      send_request(make_req(ACT_TEXT, '0, '0, 64'h3031323334353637, '0, '0));
   endtask

   task automatic test_single();
      send_request(make_req(ACT_SINGLE, '0, 31'd0, '0, 4'd0, '0));
      send_request(make_req(ACT_SINGLE, '0, 31'h7FFFFFFF, '0, 4'd15, '0));
      send_request(make_req(ACT_SINGLE, '0, 31'h5555555A, '0, 4'd5, '1));
   endtask

   task automatic test_raw();
      send_request(make_req(ACT_RAW, '0, '0, '0, 4'd0, 8'h00));
      send_request(make_req(ACT_RAW, '0, '0, '0, 4'd15, 8'hFF));
      send_request(make_req(ACT_RAW, '1, '1, '1, 4'd10, 8'h5A));
   endtask

   // spare actions give no bytes; a normal item after them must still line up
   task automatic test_spare_actions();
      send_request(make_req(ACT_SPARE_LO, '1, '1, '1, '1, '1));
      send_request(make_req(ACT_SPARE_MID, '0, '0, '0, '0, '0));
      send_request(make_req(ACT_SPARE_HI, '1, '1, '1, '1, '1));
      send_request(make_req(ACT_RAW, '0, '0, '0, 4'd3, 8'hA5));
      drain();
   endtask

   task automatic test_config();
      write_config(8'h00, 8'h00, 8'h80);
      csr_check(REG_LED_EVEN, led_even_reg);
      csr_check(REG_LED_ODD, led_odd_reg);
      csr_check(REG_DISPLAY_CTRL, display_ctrl_reg);
      send_request(make_req(ACT_HEX, 32'hA5A5A5A5, '0, '0, '0, '0));
      send_request(make_req(ACT_SINGLE, '0, 31'd9, '0, 4'd7, '0));
      drain();
      write_config(8'hFF, 8'hFF, 8'h8F);
      // index beyond the last register is ignored
      csr_write(REG_SPARE, 32'hFFFFFF12);
      csr_check(REG_LED_EVEN, led_even_reg);
      csr_check(REG_LED_ODD, led_odd_reg);
      csr_check(REG_DISPLAY_CTRL, display_ctrl_reg);
      send_request(make_req(ACT_TEXT, '0, '0, 64'h7E7D7C7B7A797877, '0, '0));
      send_request(make_req(ACT_SINGLE, '0, 31'd14, '0, 4'd12, '0));
      drain();
   endtask

   task automatic test_random(input int count, input int req_pct, input int rsp_pct);
      display_req_type r;
      int              done;
      write_config(8'($urandom), 8'($urandom), 8'($urandom_range(8'h80, 8'h8F)));
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      done = 0;
      while (done < count) begin
         r = random_req();
         send_request(r);
         if (r.action <= ACT_RAW) begin
            done++;
         end
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_hold = 0;
      end else begin
         if (pop && !empty) begin
            if (pending_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected byte, exp none act %h fe %b last %b", $time,
                        rsp_data_byte, rsp_frame_end, rsp_last);
            end else begin
               if (rsp_data_byte !== pending_bytes[0].data ||
                   rsp_frame_end !== pending_bytes[0].frame_end ||
                   rsp_last !== pending_bytes[0].last) begin
                  errors++;
                  $display("%0t: byte mismatch exp %h fe %b last %b act %h fe %b last %b",
                           $time, pending_bytes[0].data, pending_bytes[0].frame_end,
                           pending_bytes[0].last, rsp_data_byte, rsp_frame_end, rsp_last);
               end
               void'(pending_bytes.pop_front());
            end
         end
         if (pop_hold != 0) begin
            pop_hold--;
            pop <= 1'b0;
         end else begin
            pop_hold = idle_length(rsp_idle_pct);
            if (pop_hold != 0) begin
               pop_hold--;
               pop <= 1'b0;
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d bytes outstanding", $time,
                     pending_bytes.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(REG_LED_EVEN, RST_LED_EVEN);
      csr_check(REG_LED_ODD, RST_LED_ODD);
      csr_check(REG_DISPLAY_CTRL, RST_DISPLAY_CTRL);
      test_hex();
      test_decimal();
      test_text();
      test_single();
      test_raw();
      test_spare_actions();
      test_config();
      test_random(60, 0, 0);
      test_random(60, 30, 30);
      test_random(60, 60, 10);
      test_random(60, 10, 60);
      drain();
      if (errors == 0 && pending_bytes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
